// ===== rtl/z80f_pkg.sv =====
// ============================================================================
// Z80 ALU package
// Word types, action codes, flag bit masks and the carry/overflow lookup
// tables shared by the ALU core and the top level.
// ============================================================================
`default_nettype none

package z80f_pkg;

  // Flag byte layout: S Z 5 H 3 P/V N C
  localparam logic [7:0] F_C  = 8'h01;
  localparam logic [7:0] F_N  = 8'h02;
  localparam logic [7:0] F_PV = 8'h04;
  localparam logic [7:0] F_3  = 8'h08;
  localparam logic [7:0] F_H  = 8'h10;
  localparam logic [7:0] F_5  = 8'h20;
  localparam logic [7:0] F_Z  = 8'h40;
  localparam logic [7:0] F_S  = 8'h80;

  typedef enum logic [4:0] {
    ACT_ADD   = 5'd0,
    ACT_ADC   = 5'd1,
    ACT_SUB   = 5'd2,
    ACT_SBC   = 5'd3,
    ACT_AND   = 5'd4,
    ACT_XOR   = 5'd5,
    ACT_OR    = 5'd6,
    ACT_CP    = 5'd7,
    ACT_INC   = 5'd8,
    ACT_DEC   = 5'd9,
    ACT_RLC   = 5'd10,
    ACT_RRC   = 5'd11,
    ACT_RL    = 5'd12,
    ACT_RR    = 5'd13,
    ACT_SLA   = 5'd14,
    ACT_SLL   = 5'd15,
    ACT_SRA   = 5'd16,
    ACT_SRL   = 5'd17,
    ACT_BIT   = 5'd18,
    ACT_BITX  = 5'd19,
    ACT_ADD16 = 5'd20,
    ACT_ADC16 = 5'd21,
    ACT_SBC16 = 5'd22
  } action_t;

  // Indexed by {result bit, operand bit, accumulator bit}
  localparam logic [7:0] HC_ADD [8] = '{8'h00, F_H, F_H, F_H, 8'h00, 8'h00, 8'h00, F_H};
  localparam logic [7:0] HC_SUB [8] = '{8'h00, 8'h00, F_H, 8'h00, F_H, 8'h00, F_H, F_H};
  localparam logic [7:0] OV_ADD [8] = '{8'h00, 8'h00, 8'h00, F_PV, F_PV, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] OV_SUB [8] = '{8'h00, F_PV, 8'h00, 8'h00, 8'h00, 8'h00, F_PV, 8'h00};

  typedef struct packed {
    logic [4:0]  action;
    logic [7:0]  acc_in;
    logic [7:0]  operand;
    logic [7:0]  flags_in;
    logic [15:0] pair_in;
    logic [15:0] pair_operand;
    logic [2:0]  bit_select;
    logic [7:0]  addr_high;
  } z80f_in_t;

  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  flags_out;
    logic        result_valid;
  } z80f_out_t;

  function automatic logic [7:0] sz53(input logic [7:0] r);
    sz53 = (r & (F_S | F_5 | F_3)) | ((r == 8'h00) ? F_Z : 8'h00);
  endfunction

  function automatic logic [7:0] sz53p(input logic [7:0] r);
    sz53p = sz53(r) | ((^r) ? 8'h00 : F_PV);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/z80f_core.sv =====
// ============================================================================
// Z80 ALU core
// Combinational datapath: one action per word, result and new flag byte.
// ============================================================================
`default_nettype none

module z80f_core (
  input  z80f_pkg::z80f_in_t  op,
  output z80f_pkg::z80f_out_t res
);
  import z80f_pkg::*;

  logic [7:0]  a, v, f, ah;
  logic [15:0] hl, pv;
  logic        c;
  logic [8:0]  add8, sub8;
  logic [16:0] add16, sub16;
  logic [2:0]  k8_lo, k8_hi, k16_lo, k16_hi;
  logic [2:0]  ks8_lo, ks8_hi, ks16_lo, ks16_hi;
  logic [7:0]  r8;
  logic [15:0] r16;
  logic [7:0]  inc8, dec8;
  logic        tested;
  logic [7:0]  nf;
  logic [15:0] r;
  logic        valid;

  assign a  = op.acc_in;
  assign v  = op.operand;
  assign f  = op.flags_in;
  assign ah = op.addr_high;
  assign hl = op.pair_in;
  assign pv = op.pair_operand;
  assign c  = f[0];

  // Carry-in only for the with-carry forms
  assign add8  = {1'b0, a} + {1'b0, v} + {8'h00, (op.action == ACT_ADC) & c};
  assign sub8  = {1'b0, a} - {1'b0, v} - {8'h00, (op.action == ACT_SBC) & c};
  assign add16 = {1'b0, hl} + {1'b0, pv} + {16'h0000, (op.action == ACT_ADC16) & c};
  assign sub16 = {1'b0, hl} - {1'b0, pv} - {16'h0000, c};

  assign k8_lo   = {add8[3], v[3], a[3]};
  assign k8_hi   = {add8[7], v[7], a[7]};
  assign ks8_lo  = {sub8[3], v[3], a[3]};
  assign ks8_hi  = {sub8[7], v[7], a[7]};
  assign k16_lo  = {add16[11], pv[11], hl[11]};
  assign k16_hi  = {add16[15], pv[15], hl[15]};
  assign ks16_lo = {sub16[11], pv[11], hl[11]};
  assign ks16_hi = {sub16[15], pv[15], hl[15]};

  assign inc8   = a + 8'd1;
  assign dec8   = a - 8'd1;
  assign tested = a[op.bit_select];

  always_comb begin
    r8    = 8'h00;
    r16   = 16'h0000;
    nf    = f;
    valid = 1'b1;
    unique case (op.action)
      ACT_ADD, ACT_ADC: begin
        r8 = add8[7:0];
        nf = (add8[8] ? F_C : 8'h00) | HC_ADD[k8_lo] | OV_ADD[k8_hi] | sz53(r8);
      end
      ACT_SUB, ACT_SBC: begin
        r8 = sub8[7:0];
        nf = (sub8[8] ? F_C : 8'h00) | F_N | HC_SUB[ks8_lo] | OV_SUB[ks8_hi] | sz53(r8);
      end
      ACT_CP: begin
        // undocumented bits 3 and 5 follow the operand
        nf = (sub8[8] ? F_C : 8'h00) | F_N | HC_SUB[ks8_lo] | OV_SUB[ks8_hi]
           | (v & (F_3 | F_5)) | (sub8[7:0] & F_S)
           | ((sub8[7:0] == 8'h00) ? F_Z : 8'h00);
        valid = 1'b0;
      end
      ACT_AND: begin
        r8 = a & v;
        nf = F_H | sz53p(r8);
      end
      ACT_XOR: begin
        r8 = a ^ v;
        nf = sz53p(r8);
      end
      ACT_OR: begin
        r8 = a | v;
        nf = sz53p(r8);
      end
      ACT_INC: begin
        r8 = inc8;
        nf = (f & F_C) | ((inc8 == 8'h80) ? F_PV : 8'h00)
           | ((inc8[3:0] == 4'h0) ? F_H : 8'h00) | sz53(inc8);
      end
      ACT_DEC: begin
        r8 = dec8;
        nf = (f & F_C) | ((a[3:0] == 4'h0) ? F_H : 8'h00) | F_N
           | ((dec8 == 8'h7f) ? F_PV : 8'h00) | sz53(dec8);
      end
      ACT_RLC: begin
        r8 = {a[6:0], a[7]};
        nf = {7'h00, a[7]} | sz53p(r8);
      end
      ACT_RRC: begin
        r8 = {a[0], a[7:1]};
        nf = {7'h00, a[0]} | sz53p(r8);
      end
      ACT_RL: begin
        r8 = {a[6:0], c};
        nf = {7'h00, a[7]} | sz53p(r8);
      end
      ACT_RR: begin
        r8 = {c, a[7:1]};
        nf = {7'h00, a[0]} | sz53p(r8);
      end
      ACT_SLA: begin
        r8 = {a[6:0], 1'b0};
        nf = {7'h00, a[7]} | sz53p(r8);
      end
      ACT_SLL: begin
        r8 = {a[6:0], 1'b1};
        nf = {7'h00, a[7]} | sz53p(r8);
      end
      ACT_SRA: begin
        r8 = {a[7], a[7:1]};
        nf = {7'h00, a[0]} | sz53p(r8);
      end
      ACT_SRL: begin
        r8 = {1'b0, a[7:1]};
        nf = {7'h00, a[0]} | sz53p(r8);
      end
      ACT_BIT, ACT_BITX: begin
        nf = (f & F_C) | F_H
           | (((op.action == ACT_BIT) ? a : ah) & (F_3 | F_5))
           | (tested ? 8'h00 : (F_PV | F_Z))
           | (((op.bit_select == 3'd7) && tested) ? F_S : 8'h00);
        valid = 1'b0;
      end
      ACT_ADD16: begin
        r16 = add16[15:0];
        nf  = (f & (F_PV | F_Z | F_S)) | (add16[16] ? F_C : 8'h00)
            | (add16[15:8] & (F_3 | F_5)) | HC_ADD[k16_lo];
      end
      ACT_ADC16: begin
        r16 = add16[15:0];
        nf  = (add16[16] ? F_C : 8'h00) | (add16[15:8] & (F_3 | F_5 | F_S))
            | ((add16[15:0] == 16'h0000) ? F_Z : 8'h00)
            | OV_ADD[k16_hi] | HC_ADD[k16_lo];
      end
      ACT_SBC16: begin
        r16 = sub16[15:0];
        nf  = (sub16[16] ? F_C : 8'h00) | (sub16[15:8] & (F_3 | F_5 | F_S))
            | ((sub16[15:0] == 16'h0000) ? F_Z : 8'h00)
            | F_N | OV_SUB[ks16_hi] | HC_SUB[ks16_lo];
      end
      default: begin
        // undefined action: flags pass through, nothing written back
        nf    = f;
        valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    priority if (op.action == ACT_ADD16 || op.action == ACT_ADC16 ||
                 op.action == ACT_SBC16) begin
      r = r16;
    end else begin
      r = {8'h00, r8};
    end
  end

  assign res.result       = r;
  assign res.flags_out    = nf;
  assign res.result_valid = valid;

endmodule

`default_nettype wire

// ===== rtl/z80_alu_with_flags.sv =====
// ============================================================================
// Z80 ALU with flags
// Registered ALU: input word register, combinational core, result register.
// ============================================================================
`default_nettype none

// One ALU operation per word. A word is taken on every clock edge where
// start is high. busy is always low, so a new word may be offered in every
// cycle and the block sustains one word per clock. The edge that takes a
// word loads the input register. The next edge loads the result register
// through the single combinational core. The result sits on res for exactly
// one cycle with done high, and it is accepted at the edge after that.
// There is no back-pressure, so the receiver must take it in that cycle.
// Results come out in the order the words went in. Compare and bit tests
// return result_valid low and a zero result. Unused action codes pass
// flags_in through unchanged.

module z80_alu_with_flags (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  z80f_pkg::z80f_in_t   op,
  output logic                 done,
  output z80f_pkg::z80f_out_t  res
);
  import z80f_pkg::*;

  // input stage
  z80f_in_t  op_q;
  logic      op_vld;
  // core output
  z80f_out_t res_next;

  // never stalls: the result register is overwritten every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_vld <= 1'b0;
    end else begin
      op_vld <= start & ~busy;
    end
    op_q <= op;
  end

  z80f_core u_core (
    .op  (op_q),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= op_vld;
    end
    res <= res_next;
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------

  // an accepted word always lands in the input stage
  a_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> op_vld)
    else $error("accepted word missing from input stage");

  // every word in the input stage leaves as a result on the next edge
  a_flow: assert property (@(posedge clk) disable iff (rst)
    op_vld |=> done)
    else $error("result strobe lost");

  // no strobe without a word behind it
  a_nofake: assert property (@(posedge clk) disable iff (rst)
    !op_vld |=> !done)
    else $error("result strobe without a word");

  // tests and undefined actions write nothing back and carry a zero result
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !res.result_valid) |-> (res.result == 16'h0000))
    else $error("non-written result is not zero");

  // a non-zero high byte only comes from pair arithmetic, which writes back
  a_hibyte: assert property (@(posedge clk) disable iff (rst)
    (done && (res.result[15:8] != 8'h00)) |-> res.result_valid)
    else $error("high byte set on a non-written result");

endmodule

`default_nettype wire

// ===== verif/tb_z80_alu_with_flags.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Z80 ALU with flags: testbench
// Sends ALU words through the start/busy handshake and predicts the result
// and flag byte of each accepted word. Results are checked field by field,
// in order, as the done strobe marks them. A short directed set comes first,
// then random words under three sender pacing modes.
// ============================================================================

module tb_z80_alu_with_flags;
  import z80f_pkg::*;

  // Action codes past the last defined one pass the flags through
  localparam logic [4:0] ACT_FIRST_UNUSED = 5'd23;
  localparam logic [4:0] ACT_LAST_CODE    = 5'd31;

  localparam int RANDOM_WORDS = 500;     // per pacing mode
  localparam int LIMIT_CYCLES = 200000;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  z80f_in_t  op    = '0;
  logic      busy;
  logic      done;
  z80f_out_t res;

  z80f_in_t  op_q[$];         // words waiting to be offered
  z80f_out_t outcome_q[$];    // predicted results, oldest first
  z80f_out_t want;

  int unsigned idle_pct    = 0;  // chance in a hundred that the sender idles
  int unsigned offered_cnt = 0;
  int unsigned taken_cnt   = 0;
  int unsigned checked     = 0;
  int unsigned err_cnt     = 0;
  int unsigned cycle_cnt   = 0;

  z80_alu_with_flags i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .op    (op),
    .done  (done),
    .res   (res)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Flag helpers: S, Z and the two undocumented bits copied from a byte, and
  // the same with even parity on P/V.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] szxy(input logic [7:0] r);
    szxy = (r & (F_S | F_5 | F_3)) | ((r == 8'h00) ? F_Z : 8'h00);
  endfunction

  function automatic logic [7:0] szxyp(input logic [7:0] r);
    szxyp = szxy(r) | ((^r) ? 8'h00 : F_PV);
  endfunction

  // --------------------------------------------------------------------------
  // Predicted result and flag byte of one ALU word
  // --------------------------------------------------------------------------
  function automatic z80f_out_t alu_outcome(input z80f_in_t w);
    z80f_out_t   e;
    logic [8:0]  s9;
    logic [16:0] s17;
    logic [15:0] r16;
    logic [7:0]  a, v, r8, f;
    logic        c, tbit, sub16;
    a = w.acc_in;
    v = w.operand;
    c = w.flags_in[0];
    r8 = 8'h00;
    f = w.flags_in;
    e.result = 16'h0000;
    e.result_valid = 1'b1;
    case (w.action)
      ACT_ADD, ACT_ADC: begin
        s9 = {1'b0, a} + {1'b0, v} + {8'd0, (w.action == ACT_ADC) & c};
        r8 = s9[7:0];
        f = {7'd0, s9[8]} | HC_ADD[{r8[3], v[3], a[3]}] | OV_ADD[{r8[7], v[7], a[7]}]
            | szxy(r8);
      end
      ACT_SUB, ACT_SBC, ACT_CP: begin
        // bit 8 of the 9-bit difference is the borrow
        s9 = {1'b0, a} - {1'b0, v} - {8'd0, (w.action == ACT_SBC) & c};
        r8 = s9[7:0];
        f = {7'd0, s9[8]} | F_N | HC_SUB[{r8[3], v[3], a[3]}]
            | OV_SUB[{r8[7], v[7], a[7]}];
        if (w.action == ACT_CP) begin
          // compare: bits 3 and 5 follow the operand, nothing written back
          f = f | (v & (F_3 | F_5)) | (r8 & F_S) | ((r8 == 8'h00) ? F_Z : 8'h00);
          r8 = 8'h00;
          e.result_valid = 1'b0;
        end else begin
          f = f | szxy(r8);
        end
      end
      ACT_AND: begin r8 = a & v; f = F_H | szxyp(r8); end
      ACT_XOR: begin r8 = a ^ v; f = szxyp(r8); end
      ACT_OR:  begin r8 = a | v; f = szxyp(r8); end
      ACT_INC: begin
        r8 = a + 8'd1;
        f = {7'd0, c} | ((r8 == 8'h80) ? F_PV : 8'h00)
            | ((r8[3:0] == 4'h0) ? F_H : 8'h00) | szxy(r8);
      end
      ACT_DEC: begin
        r8 = a - 8'd1;
        f = {7'd0, c} | ((a[3:0] == 4'h0) ? F_H : 8'h00) | F_N
            | ((r8 == 8'h7F) ? F_PV : 8'h00) | szxy(r8);
      end
      ACT_RLC: begin r8 = {a[6:0], a[7]};  f = {7'd0, a[7]} | szxyp(r8); end
      ACT_RRC: begin r8 = {a[0], a[7:1]};  f = {7'd0, a[0]} | szxyp(r8); end
      ACT_RL:  begin r8 = {a[6:0], c};     f = {7'd0, a[7]} | szxyp(r8); end
      ACT_RR:  begin r8 = {c, a[7:1]};     f = {7'd0, a[0]} | szxyp(r8); end
      ACT_SLA: begin r8 = {a[6:0], 1'b0};  f = {7'd0, a[7]} | szxyp(r8); end
      ACT_SLL: begin r8 = {a[6:0], 1'b1};  f = {7'd0, a[7]} | szxyp(r8); end
      ACT_SRA: begin r8 = {a[7], a[7:1]};  f = {7'd0, a[0]} | szxyp(r8); end
      ACT_SRL: begin r8 = {1'b0, a[7:1]};  f = {7'd0, a[0]} | szxyp(r8); end
      ACT_BIT, ACT_BITX: begin
        tbit = a[w.bit_select];
        f = {7'd0, c} | F_H
            | (((w.action == ACT_BIT) ? a : w.addr_high) & (F_3 | F_5));
        if (!tbit) f = f | F_PV | F_Z;
        if (w.bit_select == 3'd7 && tbit) f = f | F_S;
        e.result_valid = 1'b0;
      end
      ACT_ADD16: begin
        // S, Z and P/V survive a plain 16-bit add
        s17 = {1'b0, w.pair_in} + {1'b0, w.pair_operand};
        r16 = s17[15:0];
        f = (w.flags_in & (F_PV | F_Z | F_S)) | {7'd0, s17[16]}
            | (r16[15:8] & (F_3 | F_5))
            | HC_ADD[{r16[11], w.pair_operand[11], w.pair_in[11]}];
        e.result = r16;
      end
      ACT_ADC16, ACT_SBC16: begin
        sub16 = (w.action == ACT_SBC16);
        if (sub16)
          s17 = {1'b0, w.pair_in} - {1'b0, w.pair_operand} - {16'd0, c};
        else
          s17 = {1'b0, w.pair_in} + {1'b0, w.pair_operand} + {16'd0, c};
        r16 = s17[15:0];
        f = {7'd0, s17[16]} | (r16[15:8] & (F_3 | F_5 | F_S))
            | ((r16 == 16'h0000) ? F_Z : 8'h00);
        if (sub16)
          f = f | F_N | OV_SUB[{r16[15], w.pair_operand[15], w.pair_in[15]}]
              | HC_SUB[{r16[11], w.pair_operand[11], w.pair_in[11]}];
        else
          f = f | OV_ADD[{r16[15], w.pair_operand[15], w.pair_in[15]}]
              | HC_ADD[{r16[11], w.pair_operand[11], w.pair_in[11]}];
        e.result = r16;
      end
      default: begin
        // undefined codes: flags pass through, nothing written back
        f = w.flags_in;
        e.result_valid = 1'b0;
      end
    endcase
    if (w.action <= ACT_SRL && e.result_valid) e.result = {8'h00, r8};
    e.flags_out = f;
    alu_outcome = e;
  endfunction

  function automatic z80f_in_t make_word(input logic [4:0] act, input logic [7:0] a,
                                         input logic [7:0] v, input logic [7:0] f,
                                         input logic [15:0] hl, input logic [15:0] pv,
                                         input logic [2:0] bs, input logic [7:0] ah);
    z80f_in_t w;
    w.action = act;
    w.acc_in = a;
    w.operand = v;
    w.flags_in = f;
    w.pair_in = hl;
    w.pair_operand = pv;
    w.bit_select = bs;
    w.addr_high = ah;
    make_word = w;
  endfunction

  // Bytes and pairs lean towards the carry and overflow boundaries
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       pick_byte = 8'h00;
      1:       pick_byte = 8'hFF;
      2:       pick_byte = 8'h7F;
      3:       pick_byte = 8'h80;
      default: pick_byte = 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_pair();
    case ($urandom_range(0, 7))
      0:       pick_pair = 16'h0000;
      1:       pick_pair = 16'hFFFF;
      2:       pick_pair = 16'h7FFF;
      3:       pick_pair = 16'h8000;
      4:       pick_pair = 16'h0FFF;
      default: pick_pair = 16'($urandom);
    endcase
  endfunction

  function automatic z80f_in_t random_word();
    logic [4:0] act;
    // roughly one word in ten carries an undefined code
    if ($urandom_range(0, 9) == 0)
      act = 5'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_CODE));
    else
      act = 5'($urandom_range(ACT_ADD, ACT_SBC16));
    random_word = make_word(act, pick_byte(), pick_byte(), 8'($urandom), pick_pair(),
                            pick_pair(), 3'($urandom), 8'($urandom));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: a new word goes on the port at the falling edge once the previous
  // one has been taken; taken_cnt catches up with offered_cnt on acceptance.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && taken_cnt == offered_cnt) begin
      if (op_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        op <= op_q.pop_front();
        start <= 1'b1;
        offered_cnt = offered_cnt + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check the strobed result against the oldest prediction, then
  // log a prediction for any word taken on this edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (!rst) begin
      if (done) begin
        if (outcome_q.size() == 0) begin
          err_cnt = err_cnt + 1;
          $display("%0t: unexpected result, expected none got result %04h flags %02h valid %0b",
                   $time, res.result, res.flags_out, res.result_valid);
        end else begin
          want = outcome_q.pop_front();
          checked = checked + 1;
          if (res.result !== want.result) begin
            err_cnt = err_cnt + 1;
            $display("%0t: result mismatch, expected %04h got %04h",
                     $time, want.result, res.result);
          end
          if (res.flags_out !== want.flags_out) begin
            err_cnt = err_cnt + 1;
            $display("%0t: flags mismatch, expected %02h got %02h",
                     $time, want.flags_out, res.flags_out);
          end
          if (res.result_valid !== want.result_valid) begin
            err_cnt = err_cnt + 1;
            $display("%0t: result_valid mismatch, expected %0b got %0b",
                     $time, want.result_valid, res.result_valid);
          end
        end
      end
      if (start && !busy) begin
        outcome_q.push_back(alu_outcome(op));
        taken_cnt = taken_cnt + 1;
      end
    end
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d words pending and %0d results outstanding",
               $time, op_q.size(), outcome_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    // Directed words: carry/half-carry/overflow edges, every action and
    // the undocumented-flag quirks.
    op_q.push_back(make_word(ACT_ADD,   8'hFF, 8'h01, 8'h00, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_ADD,   8'h7F, 8'h01, 8'hFF, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_ADC,   8'h0F, 8'h00, 8'h01, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_SUB,   8'h80, 8'h01, 8'h00, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_SBC,   8'h00, 8'h00, 8'h01, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_AND,   8'hF0, 8'h3C, 8'h00, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_XOR,   8'hFF, 8'hFF, 8'hFF, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_OR,    8'h80, 8'h28, 8'h00, 16'h0, 16'h0, 3'd0, 8'h00));
    // compare takes bits 3 and 5 from the operand
    op_q.push_back(make_word(ACT_CP,    8'h28, 8'h28, 8'h00, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_INC,   8'h7F, 8'h00, 8'h01, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_INC,   8'hFF, 8'h00, 8'h00, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_DEC,   8'h80, 8'h00, 8'h00, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_DEC,   8'h00, 8'h00, 8'h01, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_RLC,   8'h80, 8'h00, 8'h00, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_RRC,   8'h01, 8'h00, 8'h00, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_RL,    8'h80, 8'h00, 8'h01, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_RR,    8'h01, 8'h00, 8'h01, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_SLA,   8'hFF, 8'h00, 8'h00, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_SLL,   8'h80, 8'h00, 8'h00, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_SRA,   8'h81, 8'h00, 8'h00, 16'h0, 16'h0, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_SRL,   8'h01, 8'h00, 8'h00, 16'h0, 16'h0, 3'd0, 8'h00));
    // bit 7 set raises S; a clear bit raises Z and P/V
    op_q.push_back(make_word(ACT_BIT,   8'hA8, 8'h00, 8'h01, 16'h0, 16'h0, 3'd7, 8'h00));
    op_q.push_back(make_word(ACT_BITX,  8'h00, 8'h00, 8'h00, 16'h0, 16'h0, 3'd3, 8'h28));
    // 16-bit add keeps S, Z and P/V
    op_q.push_back(make_word(ACT_ADD16, 8'h00, 8'h00, 8'hC4, 16'hFFFF, 16'h0001, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_ADC16, 8'h00, 8'h00, 8'h01, 16'h7FFF, 16'h0000, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_SBC16, 8'h00, 8'h00, 8'h01, 16'h0000, 16'h0000, 3'd0, 8'h00));
    op_q.push_back(make_word(ACT_LAST_CODE, 8'hFF, 8'hFF, 8'hA5, 16'hFFFF, 16'hFFFF, 3'd7,
                             8'hFF));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles often, then mostly, then never
    idle_pct = 31;
    repeat (RANDOM_WORDS) op_q.push_back(random_word());
    while (op_q.size() != 0) @(posedge clk);
    idle_pct = 83;
    repeat (RANDOM_WORDS) op_q.push_back(random_word());
    while (op_q.size() != 0) @(posedge clk);
    idle_pct = 0;
    repeat (RANDOM_WORDS) op_q.push_back(random_word());

    while (op_q.size() != 0 || taken_cnt != offered_cnt || outcome_q.size() != 0)
      @(posedge clk);
    // two-stage pipe: keep clocking to catch any stray strobe
    repeat (6) @(posedge clk);

    $display("Sent %0d ALU words (all action codes incl. undefined ones) at three sender rates",
             taken_cnt);
    $display("Compared %0d results, %0d mismatches", checked, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
